/* sv/sha1_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 package
// Transaction types, round constants and state codes shared by the SHA-1
// message digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       close;
    } cmd_t;

    typedef enum logic [2:0] {
        CORE_LOAD,
        CORE_ROUND,
        CORE_FINAL,
        CORE_PAD,
        CORE_OUT
    } core_state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } pad_stage_t;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET    = 6'd56;
    localparam logic [5:0] LAST_SLOT     = 6'd63;
    localparam logic [6:0] LAST_ROUND    = 7'd79;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

endpackage

`default_nettype wire

/* sv/sha1_front.sv */
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts message transactions, drops idle ones and queues byte and close
// commands for the compression core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_front
    import sha1_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      msg_valid,
    output logic           msg_stall,
    input  wire msg_item_t msg,
    output logic           cmd_valid,
    output cmd_t           cmd,
    input  wire logic      cmd_pop
);

    cmd_t                 queue_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg;
    logic [QueuePtrW-1:0] wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg;
    logic [QueuePtrW-1:0] rd_ptr_next;
    logic [QueuePtrW:0]   count_reg;
    logic [QueuePtrW:0]   count_next;
    logic                 push;

    assign msg_stall = (count_reg == (QueuePtrW + 1)'(QueueDepth));
    assign push      = msg_valid && !msg_stall && (msg.byte_valid || msg.end_of_message);
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QueuePtrW + 1)'(push) - (QueuePtrW + 1)'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{data:     msg.data_byte,
                                       has_byte: msg.byte_valid,
                                       close:    msg.end_of_message};
        end
    end

endmodule

`default_nettype wire

/* sv/sha1_core.sv */
// ----------------------------------------------------------------------------
// SHA-1 compression core
// Shifts bytes into the message schedule, pads on close, runs one round per
// cycle and emits the digest words through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_core
    import sha1_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cmd_valid,
    input  wire cmd_t   cmd,
    output logic        cmd_pop,
    output logic        digest_valid,
    input  wire logic   digest_stall,
    output digest_item_t digest
);

    core_state_t  state_reg;
    core_state_t  state_next;
    pad_stage_t   pad_reg;
    pad_stage_t   pad_next;
    logic [5:0]   fill_reg;
    logic [5:0]   fill_next;
    logic [6:0]   round_reg;
    logic [6:0]   round_next;
    logic         closing_reg;
    logic         closing_next;
    logic         done_reg;
    logic         done_next;
    logic [2:0]   word_reg;
    logic [2:0]   word_next;
    logic [63:0]  bits_reg;
    logic [63:0]  bits_next;
    logic [31:0]  chain_reg [5];
    logic [31:0]  chain_next [5];
    logic [31:0]  vars_reg [5];
    logic [31:0]  vars_next [5];
    logic [511:0] win_reg;
    logic [511:0] win_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    digest_item_t out_reg;
    digest_item_t out_next;

    logic         push;
    logic [7:0]   push_byte;
    logic [63:0]  len_shift;
    logic [31:0]  w_new;
    logic [31:0]  f_val;
    logic [31:0]  k_val;
    logic [31:0]  t_val;
    logic         out_load;

    assign len_shift = bits_reg << {fill_reg[2:0], 3'b000};
    assign w_new = {win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416]
                    ^ win_reg[511:480]} << 1
                 | {31'd0, win_reg[95] ^ win_reg[255] ^ win_reg[447] ^ win_reg[511]};

    always_comb
    begin
        priority if (round_reg < 7'd20)
        begin
            f_val = (vars_reg[1] & vars_reg[2]) | (~vars_reg[1] & vars_reg[3]);
            k_val = K_0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k_val = K_1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (vars_reg[1] & vars_reg[2]) | (vars_reg[1] & vars_reg[3])
                  | (vars_reg[2] & vars_reg[3]);
            k_val = K_2;
        end
        else
        begin
            f_val = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k_val = K_3;
        end
        t_val = {vars_reg[0][26:0], vars_reg[0][31:27]} + f_val + vars_reg[4] + k_val
              + win_reg[511:480];
    end

    always_comb
    begin
        state_next     = state_reg;
        pad_next       = pad_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        closing_next   = closing_reg;
        done_next      = done_reg;
        word_next      = word_reg;
        bits_next      = bits_reg;
        chain_next     = chain_reg;
        vars_next      = vars_reg;
        win_next       = win_reg;
        out_next       = out_reg;
        out_load       = 1'b0;
        cmd_pop        = 1'b0;
        push           = 1'b0;
        push_byte      = '0;

        unique case (state_reg)
            CORE_LOAD:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.has_byte)
                    begin
                        push      = 1'b1;
                        push_byte = cmd.data;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (cmd.close)
                    begin
                        closing_next = 1'b1;
                        pad_next     = PAD_MARK;
                    end
                    if (cmd.has_byte && fill_reg == LAST_SLOT)
                        state_next = CORE_ROUND;
                    else if (cmd.close)
                        state_next = CORE_PAD;
                end
            end
            CORE_PAD:
            begin
                push = 1'b1;
                priority if (pad_reg == PAD_MARK)
                begin
                    push_byte = PAD_MARK_BYTE;
                    pad_next  = PAD_ZERO;
                end
                else if (pad_reg == PAD_LEN || fill_reg == LEN_OFFSET)
                begin
                    push_byte = len_shift[63:56];
                    pad_next  = PAD_LEN;
                    if (fill_reg == LAST_SLOT)
                        done_next = 1'b1;
                end
                else
                begin
                    push_byte = '0;
                end
                if (fill_reg == LAST_SLOT)
                    state_next = CORE_ROUND;
            end
            CORE_ROUND:
            begin
                win_next     = {win_reg[479:0], w_new};
                vars_next[0] = t_val;
                vars_next[1] = vars_reg[0];
                vars_next[2] = {vars_reg[1][1:0], vars_reg[1][31:2]};
                vars_next[3] = vars_reg[2];
                vars_next[4] = vars_reg[3];
                round_next   = round_reg + 1'b1;
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = CORE_FINAL;
                end
            end
            CORE_FINAL:
            begin
                for (int i = 0; i < 5; i++)
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                priority if (done_reg)
                begin
                    word_next  = '0;
                    state_next = CORE_OUT;
                end
                else if (closing_reg)
                    state_next = CORE_PAD;
                else
                    state_next = CORE_LOAD;
            end
            CORE_OUT:
            begin
                if (!out_valid_reg || !digest_stall)
                begin
                    out_load = 1'b1;
                    out_next = '{digest_word: chain_reg[word_reg],
                                 word_index:  word_reg,
                                 last_word:   (word_reg == LAST_WORD_IDX)};
                    word_next = word_reg + 1'b1;
                    if (word_reg == LAST_WORD_IDX)
                    begin
                        chain_next   = H_INIT;
                        bits_next    = '0;
                        closing_next = 1'b0;
                        done_next    = 1'b0;
                        state_next   = CORE_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = CORE_LOAD;
            end
        endcase

        if (push)
        begin
            win_next  = {win_reg[503:0], push_byte};
            fill_next = fill_reg + 1'b1;
            if (fill_reg == LAST_SLOT)
            begin
                vars_next  = chain_reg;
                round_next = '0;
            end
        end

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && digest_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CORE_LOAD;
            pad_reg       <= PAD_MARK;
            fill_reg      <= '0;
            round_reg     <= '0;
            closing_reg   <= 1'b0;
            done_reg      <= 1'b0;
            word_reg      <= '0;
            bits_reg      <= '0;
            chain_reg     <= H_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pad_reg       <= pad_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            closing_reg   <= closing_next;
            done_reg      <= done_next;
            word_reg      <= word_next;
            bits_reg      <= bits_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        vars_reg <= vars_next;
        out_reg  <= out_next;
    end

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

endmodule

`default_nettype wire

/* sv/sha1_message_digest.sv */
// Output: after a closing transaction reaches the core, the digest words
//   are emitted one word per cycle while not stalled.
// Blocks: each 64-byte block is loaded byte by byte, then gets 80 rounds in the
//   single round unit and one chaining add; a 4-entry queue buffers input.
// Reset: asynchronous, active low; clears the queue and loads the initial hash.
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-stream SHA-1 with padding and a five-word digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest
    import sha1_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         msg_valid,
    output logic              msg_stall,
    input  wire msg_item_t    msg,
    output logic              digest_valid,
    input  wire logic         digest_stall,
    output digest_item_t      digest
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    sha1_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    sha1_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("queue popped while empty");

    a_last_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_word == (digest.word_index == LAST_WORD_IDX)))
        else $error("last_word inconsistent with word_index");

    a_words_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && !digest.last_word) |=> digest_valid)
        else $error("digest word sequence broken");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Sends byte-stream messages into the SHA-1 block with random gaps and drains
// the digest with random stalls. A scoreboard works out each five-word digest
// from the accepted transactions and compares it with what the block emits.
// ----------------------------------------------------------------------------
module tb_top;
    import sha1_pkg::*;

    class digest_scoreboard;
        logic [31:0]  chain[5];
        logic [7:0]   block[64];
        int unsigned  fill;
        logic [63:0]  bit_count;
        digest_item_t pending_words[$];
        int           errors;
        int           words_checked;
        int           messages;
        int           bytes_taken;

        function new();
            errors = 0;
            words_checked = 0;
            messages = 0;
            bytes_taken = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 5; i++)
                chain[i] = H_INIT[i];
            fill = 0;
            bit_count = '0;
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress();
            logic [31:0] w[16];
            logic [31:0] a, b, c, d, e, f, k, tmp;
            for (int t = 0; t < 16; t++)
                w[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int t = 0; t < 80; t++)
            begin
                if (t >= 16)
                    w[t%16] = rotl(w[(t-3)%16] ^ w[(t-8)%16] ^ w[(t-14)%16] ^ w[t%16], 1);
                if (t < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = K_0;
                end
                else if (t < 40)
                begin
                    f = b ^ c ^ d;
                    k = K_1;
                end
                else if (t < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_2;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = K_3;
                end
                tmp = rotl(a, 5) + f + e + k + w[t%16];
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = tmp;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        function void push_byte(logic [7:0] v);
            block[fill] = v;
            fill++;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        endfunction

        function void note_input(msg_item_t it);
            logic [63:0]  len;
            digest_item_t word;
            if (it.byte_valid)
            begin
                bit_count += 64'd8;
                bytes_taken++;
                push_byte(it.data_byte);
            end
            if (!it.end_of_message)
                return;
            len = bit_count;
            push_byte(PAD_MARK_BYTE);
            while (fill != LEN_OFFSET)
                push_byte(8'h00);
            for (int i = 0; i < 8; i++)
                push_byte(len[63 - 8*i -: 8]);
            for (int i = 0; i < 5; i++)
            begin
                word.digest_word = chain[i];
                word.word_index = 3'(i);
                word.last_word = (3'(i) == LAST_WORD_IDX);
                pending_words = {pending_words, word};
            end
            messages++;
            restart();
        endfunction

        function void check_word(digest_item_t got);
            digest_item_t want;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected digest word, expected none, actual %h index %0d",
                         $time, got.digest_word, got.word_index);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (got.digest_word !== want.digest_word)
            begin
                $display("%0t: digest_word expected %h actual %h",
                         $time, want.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== want.word_index)
            begin
                $display("%0t: word_index expected %0d actual %0d",
                         $time, want.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== want.last_word)
            begin
                $display("%0t: last_word expected %0d actual %0d",
                         $time, want.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         msg_valid;
    logic         msg_stall;
    msg_item_t    msg;
    logic         digest_valid;
    logic         digest_stall;
    digest_item_t digest;

    digest_scoreboard sb = new();
    logic             calm = 1'b0;
    int               items_sent = 0;

    sha1_message_digest dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input msg_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            msg_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        msg_valid <= 1'b1;
        msg <= it;
        do
            @(posedge clk);
        while (msg_stall);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_fields(input logic [7:0] data, input logic has_byte,
                               input logic close);
        msg_item_t it;
        it.data_byte = data;
        it.byte_valid = has_byte;
        it.end_of_message = close;
        send_item(it);
    endtask

    task automatic send_message(input int len, input bit close_with_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_fields(8'($urandom), 1'b0, 1'b0);
            send_fields(8'($urandom), 1'b1, close_with_byte && (i == len - 1));
        end
        if (!close_with_byte || len == 0)
            send_fields(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain_digests();
        @(negedge clk);
        msg_valid <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        if (rst_n && digest_valid && !digest_stall)
            sb.check_word(digest);

    initial
    begin
        int  hold;
        logic stalling;
        hold = 0;
        stalling = 1'b0;
        digest_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                stalling = 1'b0;
                hold = 0;
            end
            else if (hold == 0)
            begin
                stalling = ($urandom_range(0, 3) == 0);
                hold = stalling ? pick_gap() : $urandom_range(1, 8);
            end
            else
                hold--;
            digest_stall <= stalling;
        end
    end

    initial
    begin
        int len;
        int band;
        rst_n = 1'b0;
        msg_valid = 1'b0;
        msg = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_fields(8'hA5, 1'b0, 1'b0);
        send_fields(8'h00, 1'b0, 1'b1);
        send_fields(8'h61, 1'b1, 1'b0);
        send_fields(8'h62, 1'b1, 1'b0);
        send_fields(8'h63, 1'b1, 1'b1);
        send_fields(8'h00, 1'b1, 1'b0);
        send_fields(8'hFF, 1'b1, 1'b0);
        send_fields(8'hFF, 1'b0, 1'b0);
        send_fields(8'h5A, 1'b0, 1'b1);
        send_fields(8'hFF, 1'b1, 1'b1);
        send_fields(8'h80, 1'b1, 1'b0);
        send_fields(8'h7F, 1'b1, 1'b1);

        for (int m = 0; items_sent < 130; m++)
        begin
            calm = ($urandom_range(0, 5) == 0);
            band = $urandom_range(0, 9);
            if (band < 6)
                len = $urandom_range(0, 12);
            else if (band < 9)
                len = $urandom_range(54, 65);
            else
                len = $urandom_range(100, 130);
            send_message(len, $urandom_range(0, 1));
            if (m == 0)
                drain_digests();
        end
        calm = 1'b0;

        drain_digests();
        repeat (250) @(posedge clk);
        $display("%0d bytes in %0d messages, padding across one and two blocks;",
                 sb.bytes_taken, sb.messages);
        $display("%0d digest words checked under random gaps and stalls", sb.words_checked);
        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout with %0d digest words outstanding",
                 $time, sb.pending_words.size());
        $display("status: fail");
        $finish;
    end
endmodule

/* files.f */
sv/sha1_pkg.sv
sv/sha1_front.sv
sv/sha1_core.sv
sv/sha1_message_digest.sv
verif/tb_top.sv
